### src/slt_pkg.sv
// slt_pkg: shared constants of the sine lfo tremolo block
// polynomial coefficients, register indexes, reset values and default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

    // default sizes handed to the top level
    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_BITS       = 32;
    localparam int DEF_SAMPLE_BITS      = 16;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH        = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_MODE = 2'd2;

    localparam logic [31:0] RST_PHASE_STEP   = 32'd486959;
    localparam logic [15:0] RST_DEPTH        = 16'd32768;
    localparam logic        RST_CHANNEL_MODE = 1'b1;

    // channel mode codes
    localparam logic MODE_LEFT   = 1'b0;
    localparam logic MODE_STEREO = 1'b1;

    // q2.30 coefficients of sin(pi/2 * x) for x in [0,1]
    localparam logic [31:0] SC1 = 32'd1686629713;
    localparam logic [31:0] SC3 = 32'd693598668;
    localparam logic [31:0] SC5 = 32'd85569305;
    localparam logic [31:0] SC7 = 32'd5026995;
    localparam logic [31:0] SC9 = 32'd172272;

    // q1.15 full scale of the sine and unity gain in q1.31
    localparam logic [31:0] SINE_SCALE = 32'd32767;
    localparam logic [14:0] SINE_MAX   = 15'h7FFF;
    localparam logic [31:0] GAIN_ONE   = 32'h8000_0000;

endpackage

`default_nettype wire

### src/slt_if.sv
// slt_if: handshake channels of the sine lfo tremolo block
// input frame, output word and configuration write channels
// depends on slt_pkg
`timescale 1ns / 1ps
`default_nettype none

// input frame channel
interface slt_in_if #(
    parameter int SAMPLE_BITS = slt_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

// output word channel
interface slt_out_if #(
    parameter int SAMPLE_BITS = slt_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// configuration write channel
interface slt_cfg_if import slt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/sine_lfo_tremolo.sv
// Sine LFO tremolo. Each accepted frame (left and right samples) is reduced to
// mono (average of both in stereo mode, left alone otherwise) and scaled by
// 1 + depth * sin(phase); the result is rounded and saturated, with clipped
// set when saturation occurred. The phase accumulator starts at zero after
// reset and advances by phase_step after every frame. The sine is evaluated
// from a ninth-order odd polynomial on the folded quarter wave, quantised to
// SINE_TABLE_DEPTH points per turn (a power of two, at most 65536). A frame is
// accepted in the idle state; in states X2, T7, T5, T3, T1, SIN, VAL, GAIN and
// MUL a single 32x32 multiplier produces, in turn, the seven products of the
// sine polynomial, the gain and the scaled sample, followed by one rounding
// step. The input is ready only between frames. A finished word sits in an
// output register; the next frame is accepted while it waits, and that frame
// holds in its rounding step until the previous word has been taken.
// Configuration writes are always ready; depth writes reach a running frame.
// depends on slt_pkg and slt_if
`timescale 1ns / 1ps
`default_nettype none

module sine_lfo_tremolo import slt_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int PHASE_BITS       = DEF_PHASE_BITS,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    slt_in_if.sink     i_in,
    slt_out_if.source  o_out,
    slt_cfg_if.sink    i_cfg
);

    localparam int LUT_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int TURN_SHIFT = 16 - LUT_BITS;
    localparam int MONO_W     = SAMPLE_BITS + 1;

    localparam logic signed [31:0] SAT_MAX = 32'sd2 ** (SAMPLE_BITS - 1) - 32'sd1;
    localparam logic signed [31:0] SAT_MIN = -(32'sd2 ** (SAMPLE_BITS - 1));

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_X2   = 4'd1;
    localparam logic [3:0] S_T7   = 4'd2;
    localparam logic [3:0] S_T5   = 4'd3;
    localparam logic [3:0] S_T3   = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_SIN  = 4'd6;
    localparam logic [3:0] S_VAL  = 4'd7;
    localparam logic [3:0] S_GAIN = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_RND  = 4'd10;

    // configuration registers
    logic [31:0]           r_phase_step;
    logic [15:0]           r_depth;
    logic                  r_mode;

    // sequencer and datapath registers
    logic [3:0]            r_state, n_state;
    logic [PHASE_BITS-1:0] r_phase;
    logic [31:0]           r_x, n_x;
    logic [31:0]           r_x2, n_x2;
    logic [31:0]           r_acc, n_acc;
    logic [14:0]           r_val, n_val;
    logic                  r_sin_neg, n_sin_neg;
    logic [31:0]           r_gain, n_gain;
    logic [63:0]           r_prod, n_prod;
    logic [MONO_W-1:0]     r_mag, n_mag;
    logic                  r_neg, n_neg;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out, n_sample_out;
    logic                          r_clipped, n_clipped;

    logic                          w_in_acc;
    logic                          w_out_load;
    logic [PHASE_BITS+31:0]        w_step_wide;
    logic [PHASE_BITS-1:0]         w_step;
    logic [LUT_BITS-1:0]           w_idx;
    logic [15:0]                   w_turn;
    logic [14:0]                   w_fold;
    logic signed [MONO_W-1:0]      w_mono2;
    logic [31:0]                   w_mul_a, w_mul_b;
    logic [63:0]                   w_prod;
    logic [31:0]                   w_coef;
    logic [63:0]                   w_vsum;
    logic [33:0]                   w_vraw;
    logic [63:0]                   w_sprod;
    logic [63:0]                   w_rsum;
    logic signed [31:0]            w_y;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_sample_out;
    assign o_out.clipped    = r_clipped;

    // phase step fitted to the accumulator width
    assign w_step_wide = {{PHASE_BITS{1'b0}}, r_phase_step};
    assign w_step      = w_step_wide[PHASE_BITS-1:0];

    // quarter-wave folding of the quantised phase
    assign w_idx  = r_phase[PHASE_BITS-1 -: LUT_BITS];
    assign w_turn = 16'(w_idx) << TURN_SHIFT;
    assign w_fold = w_turn[14] ? (15'h4000 - {1'b0, w_turn[13:0]}) : {1'b0, w_turn[13:0]};

    // mono value with one fraction bit
    assign w_mono2 = (r_mode == MODE_STEREO)
                   ? (MONO_W'(i_in.sample_left) + MONO_W'(i_in.sample_right))
                   : {i_in.sample_left, 1'b0};

    // shared multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_coef  = '0;
        case (r_state)
            S_X2: begin
                w_mul_a = r_x;
                w_mul_b = r_x;
            end
            S_T7: begin
                w_mul_a = r_x2;
                w_mul_b = SC9;
                w_coef  = SC7;
            end
            S_T5: begin
                w_mul_a = r_x2;
                w_mul_b = r_acc;
                w_coef  = SC5;
            end
            S_T3: begin
                w_mul_a = r_x2;
                w_mul_b = r_acc;
                w_coef  = SC3;
            end
            S_T1: begin
                w_mul_a = r_x2;
                w_mul_b = r_acc;
                w_coef  = SC1;
            end
            S_SIN: begin
                w_mul_a = r_x;
                w_mul_b = r_acc;
            end
            S_VAL: begin
                w_mul_a = r_acc;
                w_mul_b = SINE_SCALE;
            end
            S_GAIN: begin
                w_mul_a = 32'(r_depth);
                w_mul_b = 32'(r_val);
            end
            S_MUL: begin
                w_mul_a = 32'(r_mag);
                w_mul_b = r_gain;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // sine magnitude rounding
    assign w_vsum = w_prod + 64'h2000_0000;
    assign w_vraw = w_vsum[63:30];

    // signed product, round half up, drop 32 fraction bits
    assign w_sprod = r_neg ? (64'd0 - r_prod) : r_prod;
    assign w_rsum  = w_sprod + 64'h8000_0000;
    assign w_y     = signed'(w_rsum[63:32]);

    assign w_out_load = (r_state == S_RND) && (!r_out_valid || o_out.ready);

    // sequencer next state and datapath
    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_x2         = r_x2;
        n_acc        = r_acc;
        n_val        = r_val;
        n_sin_neg    = r_sin_neg;
        n_gain       = r_gain;
        n_prod       = r_prod;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_sample_out = r_sample_out;
        n_clipped    = r_clipped;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_x       = {1'b0, w_fold, 16'h0000};
                    n_sin_neg = w_turn[15];
                    n_neg     = w_mono2[MONO_W-1];
                    n_mag     = w_mono2[MONO_W-1] ? MONO_W'(-w_mono2) : MONO_W'(w_mono2);
                    n_state   = S_X2;
                end
            end
            S_X2: begin
                n_x2    = w_prod[61:30];
                n_state = S_T7;
            end
            S_T7: begin
                n_acc   = w_coef - w_prod[61:30];
                n_state = S_T5;
            end
            S_T5: begin
                n_acc   = w_coef - w_prod[61:30];
                n_state = S_T3;
            end
            S_T3: begin
                n_acc   = w_coef - w_prod[61:30];
                n_state = S_T1;
            end
            S_T1: begin
                n_acc   = w_coef - w_prod[61:30];
                n_state = S_SIN;
            end
            S_SIN: begin
                n_acc   = w_prod[61:30];
                n_state = S_VAL;
            end
            S_VAL: begin
                n_val   = (w_vraw > 34'(SINE_MAX)) ? SINE_MAX : w_vraw[14:0];
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_gain  = r_sin_neg ? (GAIN_ONE - w_prod[31:0]) : (GAIN_ONE + w_prod[31:0]);
                n_state = S_MUL;
            end
            S_MUL: begin
                // scaled sample kept until the rounding step can unload it
                n_prod  = w_prod;
                n_state = S_RND;
            end
            S_RND: begin
                if (w_out_load) begin
                    if (w_y > SAT_MAX) begin
                        n_sample_out = SAMPLE_BITS'(SAT_MAX);
                        n_clipped    = 1'b1;
                    end else if (w_y < SAT_MIN) begin
                        n_sample_out = SAMPLE_BITS'(SAT_MIN);
                        n_clipped    = 1'b1;
                    end else begin
                        n_sample_out = SAMPLE_BITS'(w_y);
                        n_clipped    = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
            r_phase_step <= RST_PHASE_STEP;
            r_depth      <= RST_DEPTH;
            r_mode       <= RST_CHANNEL_MODE;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_phase <= r_phase + w_step;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_PHASE_STEP:   r_phase_step <= i_cfg.data;
                    REG_DEPTH:        r_depth      <= i_cfg.data[15:0];
                    REG_CHANNEL_MODE: r_mode       <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_x2         <= n_x2;
        r_acc        <= n_acc;
        r_val        <= n_val;
        r_sin_neg    <= n_sin_neg;
        r_gain       <= n_gain;
        r_mag        <= n_mag;
        r_neg        <= n_neg;
        r_prod       <= n_prod;
        r_sample_out <= n_sample_out;
        r_clipped    <= n_clipped;
    end

`ifndef SYNTH
    // an accepted frame starts the polynomial
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_in_acc) |=> (r_state == S_X2))
        else $error("accepted frame did not start the sequencer");

    // phase advances by exactly one step per accepted frame
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_in_acc) |=> (r_phase == $past(r_phase + w_step)))
        else $error("phase accumulator did not advance by the step");

    // a new word appears only out of the rounding step
    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RND))
        else $error("output word loaded outside the rounding step");

    // a clipped word carries a saturation bound
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clipped) |->
        (r_sample_out == SAMPLE_BITS'(SAT_MAX) || r_sample_out == SAMPLE_BITS'(SAT_MIN)))
        else $error("clipped word is not at a saturation bound");

    // the gain never collapses to zero
    a_gain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_gain != 32'd0))
        else $error("gain is zero");
`endif

endmodule

`default_nettype wire
